// ===== rtl/mfe_pkg.sv =====
package mfe_pkg;

   localparam int WORD_BITS = 16;
   localparam int CMD_BITS = 16;
   localparam int CFG_BITS = 4;
   localparam int CSR_INDEX_BITS = 1;

   // start half-bit, two half-bits per data bit, release half-bit
   localparam int FRAME_BASE = 2 + 2 * WORD_BITS;
   // longest frame plus one, so half_index + 1 fits
   localparam int HALF_BITS = $clog2(FRAME_BASE + 16);

   localparam logic [CSR_INDEX_BITS-1:0] REG_REPEAT_COUNT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAP_HALFBITS = 1'd1;

   localparam logic [CFG_BITS-1:0] REPEAT_COUNT_RESET = 4'd11;
   localparam logic [CFG_BITS-1:0] GAP_HALFBITS_RESET = 4'd5;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_START = 1'b1;

endpackage

// ===== rtl/mfe_level.sv =====
module mfe_level (
   input  logic [mfe_pkg::WORD_BITS-1:0] held_word,
   input  logic [mfe_pkg::HALF_BITS-1:0] half_index,
   output logic                          level
);

   logic [mfe_pkg::HALF_BITS-1:0] pos_m1;
   logic [mfe_pkg::HALF_BITS-2:0] bit_num;
   logic [mfe_pkg::WORD_BITS-1:0] shifted;
   logic                          data_bit;

   assign pos_m1 = half_index - mfe_pkg::HALF_BITS'(1);
   assign bit_num = pos_m1[mfe_pkg::HALF_BITS-1:1];
   // msb first: shift the selected bit up to the top
   assign shifted = held_word << bit_num;
   assign data_bit = shifted[mfe_pkg::WORD_BITS-1];

   always_comb begin
      if (half_index == '0) begin
         level = 1'b0;
      end else if (half_index > mfe_pkg::HALF_BITS'(2 * mfe_pkg::WORD_BITS)) begin
         level = 1'b1;
      end else begin
         // second half of each bit is the complement
         level = pos_m1[0] ? ~data_bit : data_bit;
      end
   end

endmodule

// ===== rtl/manchester_frame_encoder.sv =====
// Manchester frame encoder for a one-wire command line.
// Request channel (req_valid/req_ready): req_op selects a half-bit tick or a
// start; a start loads req_cmd_word when idle and is ignored while busy.
// Every request item gives exactly one response item on rsp_valid/rsp_ready:
// rsp_line_level is the level for that half-bit (high when idle),
// rsp_busy_res shows a transmission in progress, rsp_frame_end marks the
// last half-bit of the final repetition.
// Config channel (csr_valid/csr_ready, always ready): index 0 sets the
// repeat count (zero acts as one), index 1 the number of high gap
// half-bits after each frame. Write only while no item is in flight.
// The response appears in the cycle after its request; while rsp_ready is
// high, one item per cycle is sustained by the single output register.
// When the receiver stalls, the response register holds its item and
// req_ready drops until it is taken; a new item is accepted in the same
// cycle the held one leaves.
// Synchronous reset: idle, line high, repeat count 11, gap 5, no response.
module manchester_frame_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [mfe_pkg::CMD_BITS-1:0]        req_cmd_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_line_level,
   output logic                                rsp_busy_res,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mfe_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mfe_pkg::CFG_BITS-1:0]        csr_wdata
);

   logic [mfe_pkg::CFG_BITS-1:0]  repeat_count_ff;
   logic [mfe_pkg::CFG_BITS-1:0]  gap_halfbits_ff;
   logic [mfe_pkg::WORD_BITS-1:0] held_word_ff, held_word_in;
   logic [mfe_pkg::HALF_BITS-1:0] half_index_ff, half_index_in;
   logic [mfe_pkg::CFG_BITS-1:0]  repeats_sent_ff, repeats_sent_in;
   logic                          active_ff, active_in;
   logic                          line_state_ff, line_state_in;
   logic                          frame_end_in;

   logic                          rsp_valid_ff;
   logic                          rsp_line_level_ff;
   logic                          rsp_busy_res_ff;
   logic                          rsp_frame_end_ff;

   logic                          req_fire;
   logic                          level;
   logic [mfe_pkg::HALF_BITS-1:0] total;
   logic [mfe_pkg::HALF_BITS-1:0] half_next;
   logic [mfe_pkg::CFG_BITS-1:0]  need;
   logic [mfe_pkg::CFG_BITS-1:0]  repeats_next;

   assign csr_ready = 1'b1;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire = req_valid & req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_line_level = rsp_line_level_ff;
   assign rsp_busy_res = rsp_busy_res_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   mfe_level u_level (
      .held_word  (held_word_ff),
      .half_index (half_index_ff),
      .level      (level)
   );

   assign total = mfe_pkg::HALF_BITS'(mfe_pkg::FRAME_BASE) + mfe_pkg::HALF_BITS'(gap_halfbits_ff);
   assign half_next = half_index_ff + mfe_pkg::HALF_BITS'(1);
   assign need = (repeat_count_ff == '0) ? mfe_pkg::CFG_BITS'(1) : repeat_count_ff;
   assign repeats_next = repeats_sent_ff + mfe_pkg::CFG_BITS'(1);

   always_comb begin
      held_word_in = held_word_ff;
      half_index_in = half_index_ff;
      repeats_sent_in = repeats_sent_ff;
      active_in = active_ff;
      line_state_in = line_state_ff;
      frame_end_in = 1'b0;
      if (req_op == mfe_pkg::OP_START) begin
         if (!active_ff) begin
            held_word_in = mfe_pkg::WORD_BITS'(req_cmd_word);
            half_index_in = '0;
            repeats_sent_in = '0;
            active_in = 1'b1;
         end
      end else if (active_ff) begin
         line_state_in = level;
         // a shortened gap can leave the position past the new frame end
         if (half_next >= total) begin
            half_index_in = '0;
            repeats_sent_in = repeats_next;
            if (repeats_next >= need) begin
               active_in = 1'b0;
               line_state_in = 1'b1;
               frame_end_in = 1'b1;
            end
         end else begin
            half_index_in = half_next;
         end
      end else begin
         line_state_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_count_ff <= mfe_pkg::REPEAT_COUNT_RESET;
         gap_halfbits_ff <= mfe_pkg::GAP_HALFBITS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mfe_pkg::REG_REPEAT_COUNT: begin
               repeat_count_ff <= csr_wdata;
            end
            mfe_pkg::REG_GAP_HALFBITS: begin
               gap_halfbits_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_word_ff <= '0;
         half_index_ff <= '0;
         repeats_sent_ff <= '0;
         active_ff <= 1'b0;
         line_state_ff <= 1'b1;
      end else if (req_fire) begin
         held_word_ff <= held_word_in;
         half_index_ff <= half_index_in;
         repeats_sent_ff <= repeats_sent_in;
         active_ff <= active_in;
         line_state_ff <= line_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_line_level_ff <= line_state_in;
         rsp_busy_res_ff <= active_in;
         rsp_frame_end_ff <= frame_end_in;
      end
   end

endmodule
